### design/bmp_pkg.sv
// Shared constants, payload types and multiplier interface types of the binomial unit.
package bmp_pkg;

	// Largest r that is computed; a larger valid r is reported as too large.
	localparam int MAX_R = 1048576;
	localparam int CNT_W = $clog2(MAX_R + 1);
	localparam logic signed [63:0] MAX_R_S = 64'(MAX_R);

	// The prime modulus and its Montgomery constants for R = 2^32.
	localparam logic [29:0] P_MOD     = 30'd998244353;
	localparam logic [31:0] P_NEG_INV = 32'd998244351;	// -1/p mod 2^32
	localparam logic [29:0] MONT_ONE  = 30'd301989884;	// 2^32 mod p
	localparam logic [29:0] MONT_R2   = 30'd932051910;	// 2^64 mod p
	localparam logic [29:0] INV_EXP   = 30'd998244351;	// p - 2

	typedef struct packed {
		logic signed [63:0] n;
		logic signed [63:0] r;
	} arg_item_t;

	typedef struct packed {
		logic [29:0] value;
		logic        r_too_large;
	} res_item_t;

	typedef struct packed {
		logic        start;
		logic [29:0] a;
		logic [29:0] b;
	} mm_req_t;

	typedef struct packed {
		logic        done;
		logic [29:0] value;
	} mm_rsp_t;

endpackage

### design/bmp_montmul.sv
// Multi-cycle Montgomery multiplier modulo p built around one shared 32x32 multiplier.
module bmp_montmul (
	input  logic            clk,
	input  logic            arst_n,
	input  bmp_pkg::mm_req_t req,
	output bmp_pkg::mm_rsp_t rsp
);
	import bmp_pkg::*;

	typedef enum logic [2:0] {PH_IDLE, PH_AB, PH_M, PH_MP, PH_ADD, PH_SUB} phase_t;

	phase_t      phase_q;
	logic [29:0] a_q;
	logic [29:0] b_q;
	logic [59:0] t_q;
	logic [31:0] m_q;
	logic [61:0] mp_q;
	logic [30:0] u_q;
	logic [29:0] res_q;
	logic        done_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [62:0] sum;
	logic [30:0] u_red;

	// The single multiplier serves a*b, then the Montgomery quotient, then quotient*p.
	always_comb begin
		case (phase_q)
			PH_AB: begin
				mul_a = {2'b00, a_q};
				mul_b = {2'b00, b_q};
			end
			PH_M: begin
				mul_a = t_q[31:0];
				mul_b = P_NEG_INV;
			end
			PH_MP: begin
				mul_a = m_q;
				mul_b = {2'b00, P_MOD};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign sum   = {3'b000, t_q} + {1'b0, mp_q};
	assign u_red = (u_q >= {1'b0, P_MOD}) ? (u_q - {1'b0, P_MOD}) : u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			t_q     <= '0;
			m_q     <= '0;
			mp_q    <= '0;
			u_q     <= '0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						phase_q <= PH_AB;
					end
				end
				PH_AB: begin
					t_q     <= mul_p[59:0];
					phase_q <= PH_M;
				end
				PH_M: begin
					m_q     <= mul_p[31:0];
					phase_q <= PH_MP;
				end
				PH_MP: begin
					mp_q    <= mul_p[61:0];
					phase_q <= PH_ADD;
				end
				PH_ADD: begin
					// The low 32 bits of the sum are zero by construction.
					u_q     <= sum[62:32];
					phase_q <= PH_SUB;
				end
				PH_SUB: begin
					res_q   <= u_red[29:0];
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

### design/binomial_mod_prime_unit.sv
// Top level of the binomial coefficient unit: C(n, r) modulo 998244353.
//
// Each transaction on the arg channel carries a signed pair (n, r) and yields exactly one
// transaction on the res channel. A pair with r < 0, n < 0 or r > n gives value 0; a valid
// pair with r above MAX_R gives value 0 with r_too_large set. Both of these answers are
// presented in the cycle right after acceptance. Any other pair is computed in full. First n
// is reduced modulo p. Its upper 32-bit half passes through three compare-and-subtract
// steps against 4p, 2p and p, one step per cycle. The reduced upper half is scaled by 2^32
// with one Montgomery multiplication, the lower half is added, and the sum passes through
// the same three steps. Then the falling product and r factorial are built with one
// Montgomery multiplication each per unit of r. The inverse of the factorial is raised as
// its (p-2)-th power (58 further multiplications), and a last multiplication forms the
// answer. All multiplications go through one shared Montgomery multiplier. The unit holds
// stall high on the arg channel while an item is in work. It also holds stall while a
// finished result waits in the output register under stall. A new pair is taken at the
// same edge at which the waiting result leaves.
module binomial_mod_prime_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               arg_valid,
	output logic               arg_stall,
	input  bmp_pkg::arg_item_t arg,
	output logic               res_valid,
	input  logic               res_stall,
	output bmp_pkg::res_item_t res
);
	import bmp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MODHI, ST_NHI, ST_MODLO, ST_NUM, ST_DEN, ST_TOMONT, ST_SQR, ST_MULB,
		ST_FINAL, ST_DONE
	} state_t;

	state_t             state_q;
	logic               pend_q;
	logic [31:0]        n_lo_q;
	logic [32:0]        red_q;
	logic [1:0]         step_q;
	logic [29:0]        x_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   fac_q;
	logic [29:0]        num_q;
	logic [29:0]        den_q;
	logic [29:0]        base_q;
	logic [29:0]        acc_q;
	logic [4:0]         e_idx_q;
	logic               res_valid_q;
	res_item_t          res_q;

	logic               out_free;
	logic               accept;
	logic               bad_pair;
	logic               r_over;
	logic               res_set;
	logic [32:0]        red_sub;
	logic [32:0]        red_next;
	logic               op_needed;
	mm_req_t            mm_req;
	mm_rsp_t            mm_rsp;

	// The output register can take a new result when it is empty or is being emptied now.
	assign out_free  = !res_valid_q || !res_stall;
	assign arg_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = arg_valid && !arg_stall;
	assign bad_pair  = arg.r[63] || arg.n[63] || (arg.r > arg.n);
	assign r_over    = (arg.r > MAX_R_S);

	// A result is loaded either straight from an accepted short-cut pair or from the finished
	// computation.
	assign res_set = (accept && (bad_pair || r_over)) || ((state_q == ST_DONE) && out_free);

	// One compare-and-subtract step of the reduction of n, against 4p, 2p or p.
	always_comb begin
		case (step_q)
			2'd2: begin
				red_sub = {1'b0, P_MOD, 2'b00};
			end
			2'd1: begin
				red_sub = {2'b00, P_MOD, 1'b0};
			end
			default: begin
				red_sub = {3'b000, P_MOD};
			end
		endcase
	end

	assign red_next = (red_q >= red_sub) ? (red_q - red_sub) : red_q;

	// A multiplication is launched whenever the current step needs one and none is in flight.
	always_comb begin
		op_needed = (state_q inside {ST_NHI, ST_DEN, ST_TOMONT, ST_SQR, ST_MULB, ST_FINAL}) ||
		            ((state_q == ST_NUM) && (k_q != '0));
		mm_req.start = op_needed && !pend_q;
		case (state_q)
			ST_NHI: begin
				mm_req.a = red_q[29:0];
				mm_req.b = MONT_R2;
			end
			ST_NUM: begin
				mm_req.a = num_q;
				mm_req.b = x_q;
			end
			ST_DEN: begin
				mm_req.a = den_q;
				mm_req.b = 30'(fac_q);
			end
			ST_TOMONT: begin
				mm_req.a = den_q;
				mm_req.b = MONT_R2;
			end
			ST_SQR: begin
				mm_req.a = acc_q;
				mm_req.b = acc_q;
			end
			ST_MULB: begin
				mm_req.a = acc_q;
				mm_req.b = base_q;
			end
			ST_FINAL: begin
				mm_req.a = num_q;
				mm_req.b = acc_q;
			end
			default: begin
				mm_req.a = '0;
				mm_req.b = '0;
			end
		endcase
	end

	bmp_montmul u_montmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	// Both products are kept in Montgomery-scaled form; the scale factors cancel in the
	// quotient, and converting the factorial with R^2 before the power restores plain form.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			n_lo_q      <= '0;
			red_q       <= '0;
			step_q      <= '0;
			x_q         <= '0;
			k_q         <= '0;
			fac_q       <= '0;
			num_q       <= '0;
			den_q       <= '0;
			base_q      <= '0;
			acc_q       <= '0;
			e_idx_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (mm_req.start) begin
				pend_q <= 1'b1;
			end else if (mm_rsp.done) begin
				pend_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bad_pair) begin
							res_q.value       <= '0;
							res_q.r_too_large <= 1'b0;
						end else if (r_over) begin
							res_q.value       <= '0;
							res_q.r_too_large <= 1'b1;
						end else begin
							n_lo_q  <= arg.n[31:0];
							red_q   <= {2'b00, arg.n[62:32]};
							step_q  <= 2'd2;
							k_q     <= arg.r[CNT_W-1:0];
							state_q <= ST_MODHI;
						end
					end
				end
				ST_MODHI: begin
					red_q  <= red_next;
					step_q <= step_q - 2'd1;
					if (step_q == 2'd0) begin
						state_q <= ST_NHI;
					end
				end
				ST_NHI: begin
					// The reduced upper half times 2^32, plus the lower half, stays below 8p.
					if (mm_rsp.done) begin
						red_q   <= {3'b000, mm_rsp.value} + {1'b0, n_lo_q};
						step_q  <= 2'd2;
						state_q <= ST_MODLO;
					end
				end
				ST_MODLO: begin
					red_q  <= red_next;
					step_q <= step_q - 2'd1;
					if (step_q == 2'd0) begin
						x_q     <= red_next[29:0];
						num_q   <= 30'd1;
						den_q   <= 30'd1;
						fac_q   <= CNT_W'(1);
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (k_q == '0) begin
						state_q <= ST_TOMONT;
					end else if (mm_rsp.done) begin
						num_q   <= mm_rsp.value;
						state_q <= ST_DEN;
					end
				end
				ST_DEN: begin
					if (mm_rsp.done) begin
						den_q   <= mm_rsp.value;
						k_q     <= k_q - CNT_W'(1);
						fac_q   <= fac_q + CNT_W'(1);
						// The next falling factor, (n - i) mod p, wraps at zero.
						x_q     <= (x_q == '0) ? (P_MOD - 30'd1) : (x_q - 30'd1);
						state_q <= ST_NUM;
					end
				end
				ST_TOMONT: begin
					if (mm_rsp.done) begin
						base_q  <= mm_rsp.value;
						acc_q   <= MONT_ONE;
						e_idx_q <= 5'd29;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mm_rsp.done) begin
						acc_q <= mm_rsp.value;
						if (INV_EXP[e_idx_q]) begin
							state_q <= ST_MULB;
						end else if (e_idx_q == '0) begin
							state_q <= ST_FINAL;
						end else begin
							e_idx_q <= e_idx_q - 5'd1;
						end
					end
				end
				ST_MULB: begin
					if (mm_rsp.done) begin
						acc_q <= mm_rsp.value;
						if (e_idx_q == '0) begin
							state_q <= ST_FINAL;
						end else begin
							e_idx_q <= e_idx_q - 5'd1;
							state_q <= ST_SQR;
						end
					end
				end
				ST_FINAL: begin
					if (mm_rsp.done) begin
						num_q   <= mm_rsp.value;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_q.value       <= num_q;
						res_q.r_too_large <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// An oversized r must never come with a nonzero value.
	a_too_large_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.r_too_large || (res.value == '0)))
		else $error("r_too_large result carries a nonzero value");

	// Every delivered value is a reduced residue.
	a_value_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.value < P_MOD))
		else $error("result value is not reduced modulo p");

	// The multiplier only answers a request that the sequencer has outstanding.
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> pend_q)
		else $error("multiplier finished without an outstanding request");

	// No new request is issued while one is still in flight.
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |=> !mm_req.start)
		else $error("multiplier request issued twice in a row");
`endif

endmodule
